@@ rtl/lr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the line rasteriser.
// No dependencies; every other file imports this package.
package lr_pkg;

  localparam int unsigned COORD_W   = 6;             // endpoint coordinate width
  localparam int unsigned POS_W     = COORD_W + 1;   // walking coordinate, room to step past the end
  localparam int unsigned CNT_W     = COORD_W;       // pixel counter and deltas, up to 63
  localparam int unsigned ERR_W     = COORD_W + 4;   // error term, scaled by 2*major
  localparam int unsigned FRAME_W   = 6;
  localparam int unsigned MAX_FRAME = 32;
  localparam int unsigned PIX_X_W   = 5;
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    logic [CNT_W-1:0]        major;
    logic [CNT_W-1:0]        minor;
    logic                    x_major;
  } lr_line_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ERR_W-1:0] err;
  } lr_walk_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } lr_state_e;

  // Clamp a written frame size into 1..MAX_FRAME
  function automatic logic [FRAME_W-1:0] sat_frame(input logic [FRAME_W-1:0] v);
    logic [FRAME_W-1:0] r;
    if (v == '0) begin
      r = FRAME_W'(1);
    end else if (v > FRAME_W'(MAX_FRAME)) begin
      r = FRAME_W'(MAX_FRAME);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/lr_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: line words in, pixel words out.
// Depends on lr_pkg for field widths.
interface lr_line_if import lr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        color;

  modport source (output valid, start_x, start_y, end_x, end_y, color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, color, output ready);
endinterface

interface lr_pixel_if import lr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PIX_X_W-1:0]        pixel_x;
  logic signed [COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]         address;
  logic                      visible;
  logic [COLOR_W-1:0]        pixel_color;
  logic                      last;

  modport source (output valid, pixel_x, pixel_y, address, visible, pixel_color, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, address, visible, pixel_color, last,
                  output ready);
endinterface

@@ rtl/lr_step.sv @@
`timescale 1ns / 1ps
// Walk step unit: advances position and error term by one pixel.
// Depends on lr_pkg; used once per pixel by the top-level sequencer.
module lr_step import lr_pkg::*; (
  input  lr_line_t line_i,
  input  lr_walk_t cur_i,
  output lr_walk_t nxt_o
);

  function automatic logic signed [POS_W-1:0] step_toward(
    input logic signed [POS_W-1:0] cur,
    input logic signed [POS_W-1:0] tgt
  );
    return (cur > tgt) ? cur - POS_W'(1) : cur + POS_W'(1);
  endfunction

  logic signed [ERR_W-1:0] major_s;
  logic signed [ERR_W-1:0] minor_s;
  logic signed [ERR_W-1:0] err_sub;
  logic                    minor_step;

  assign major_s    = $signed(ERR_W'(line_i.major));
  assign minor_s    = $signed(ERR_W'(line_i.minor));
  assign err_sub    = cur_i.err - (minor_s <<< 1);
  assign minor_step = (err_sub <= -major_s);

  always_comb begin
    nxt_o     = cur_i;
    nxt_o.err = minor_step ? err_sub + (major_s <<< 1) : err_sub;
    if (line_i.x_major || minor_step) begin
      nxt_o.x = step_toward(cur_i.x, line_i.end_x);
    end
    if (!line_i.x_major || minor_step) begin
      nxt_o.y = step_toward(cur_i.y, line_i.end_y);
    end
  end

endmodule

@@ rtl/line_rasterizer.sv @@
`timescale 1ns / 1ps
// Line rasteriser top: one line word in, |major|+1 pixel words out.
// First pixel word: registered in the output stage from the walk start position once the
// accept has moved the sequencer to DRAW. Throughput: one pixel per cycle from the single
// walk step unit while the pixel output is not stalled; ready returns as the last pixel is registered.
// Lines with a negative x endpoint are dropped in the accept cycle.
// Reset: asynchronous, clears control state; frame width and height return to 32.
module line_rasterizer import lr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FRAME_W-1:0]   cfg_data_i,
  lr_line_if.sink              line_i,
  lr_pixel_if.source           pixel_o
);

  lr_state_e          state_q, state_d;
  lr_line_t           line_q, line_d;
  lr_walk_t           walk_q, walk_d, walk_nxt;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COLOR_W-1:0] color_q;
  logic [FRAME_W-1:0] fw_q, fw_d, fh_q, fh_d;

  logic                      out_valid_q, out_valid_d;
  logic [PIX_X_W-1:0]        px_q;
  logic signed [COORD_W-1:0] py_q;
  logic [ADDR_W-1:0]         addr_q;
  logic                      vis_q;
  logic [COLOR_W-1:0]        pcol_q;
  logic                      last_q;

  logic                    in_fire, reject, load_out, last_pix;
  logic signed [POS_W-1:0] sx, sy, ex, ey, dx_s, dy_s;
  logic [CNT_W-1:0]        dx, dy;

  logic signed [POS_W:0]             x_c, y_c, fw_c, fh_c;
  logic                              vis;
  logic [COORD_W+FRAME_W-1:0]        prod;
  logic [ADDR_W-1:0]                 addr;

  lr_step u_step (
    .line_i (line_q),
    .cur_i  (walk_q),
    .nxt_o  (walk_nxt)
  );

  // Line setup at accept
  assign line_i.ready = (state_q == ST_IDLE);
  assign in_fire      = line_i.valid && line_i.ready;
  assign reject       = line_i.start_x[COORD_W-1] || line_i.end_x[COORD_W-1];

  assign sx   = POS_W'(line_i.start_x);
  assign sy   = POS_W'(line_i.start_y);
  assign ex   = POS_W'(line_i.end_x);
  assign ey   = POS_W'(line_i.end_y);
  assign dx_s = ex - sx;
  assign dy_s = ey - sy;
  assign dx   = dx_s[POS_W-1] ? CNT_W'(-dx_s) : CNT_W'(dx_s);
  assign dy   = dy_s[POS_W-1] ? CNT_W'(-dy_s) : CNT_W'(dy_s);

  // Pixel attributes from the current walk position
  assign x_c  = (POS_W+1)'(walk_q.x);
  assign y_c  = (POS_W+1)'(walk_q.y);
  assign fw_c = $signed((POS_W+1)'(fw_q));
  assign fh_c = $signed((POS_W+1)'(fh_q));
  assign vis  = (x_c > 0) && (x_c < fw_c) && (y_c > 0) && (y_c < fh_c);
  assign prod = walk_q.y[COORD_W-1:0] * fw_q;
  assign addr = vis ? ADDR_W'(walk_q.x[PIX_X_W-1:0]) + prod[ADDR_W-1:0] : '0;

  assign load_out = (state_q == ST_DRAW) && (!out_valid_q || pixel_o.ready);
  assign last_pix = (cnt_q == line_q.major);

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    walk_d      = walk_q;
    cnt_d       = cnt_q;
    fw_d        = fw_q;
    fh_d        = fh_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_d = sat_frame(cfg_data_i);
        REG_FRAME_HEIGHT: fh_d = sat_frame(cfg_data_i);
        default: ;
      endcase
    end

    if (pixel_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && !reject) begin
          line_d.end_x   = ex;
          line_d.end_y   = ey;
          line_d.x_major = (dx >= dy);
          line_d.major   = (dx >= dy) ? dx : dy;
          line_d.minor   = (dx >= dy) ? dy : dx;
          walk_d.x       = sx;
          walk_d.y       = sy;
          walk_d.err     = '0;
          cnt_d          = '0;
          state_d        = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          walk_d      = walk_nxt;
          cnt_d       = cnt_q + CNT_W'(1);
          if (last_pix) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fw_q        <= FRAME_W'(MAX_FRAME);
      fh_q        <= FRAME_W'(MAX_FRAME);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    walk_q <= walk_d;
    if (in_fire) begin
      color_q <= line_i.color;
    end
    // hold the output word until it is taken
    if (load_out) begin
      px_q   <= walk_q.x[PIX_X_W-1:0];
      py_q   <= walk_q.y[COORD_W-1:0];
      addr_q <= addr;
      vis_q  <= vis;
      pcol_q <= color_q;
      last_q <= last_pix;
    end
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_x     = px_q;
  assign pixel_o.pixel_y     = py_q;
  assign pixel_o.address     = addr_q;
  assign pixel_o.visible     = vis_q;
  assign pixel_o.pixel_color = pcol_q;
  assign pixel_o.last        = last_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (cnt_q <= line_q.major))
    else $error("pixel count ran past the major delta");

  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |->
      ((walk_q.err <= $signed(ERR_W'(line_q.major))) &&
       (walk_q.err >= -$signed(ERR_W'(line_q.major)))))
    else $error("error term left its range");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && reject) |=> (state_q == ST_IDLE))
    else $error("line with negative x was drawn");

  a_hidden_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !vis_q) |-> (addr_q == '0))
    else $error("hidden pixel carries an address");

endmodule
